// ----- src/ppt_pkg.sv -----
// shared constants, codes and control structs of the promotable priority table
package ppt_pkg;

    localparam int ENTRIES  = 64;
    localparam int ID_W     = $clog2(ENTRIES);
    localparam int CNT_W    = ID_W + 1;
    localparam int PRIO_W   = 16;
    localparam int PAY_W    = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PROMOTE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GET     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POP     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_init;
        logic scan_run;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_scan;
        logic scan_end;
        logic out_free;
    } t_stat;

endpackage

// ----- src/promotable_priority_table_core.sv -----
// top level of the promotable priority table: controller, datapath and checks
// add, promote, get and unused modes pass decode and finish before the result register
// peek and pop add a scan and a fetch of the winner: one table entry read per cycle
// throughput: one request in flight; a new request is taken as soon as the controller is idle
// the result register lets a new request enter while the previous result is still stalled
// reset (synchronous, active low) clears the id count, all live marks and the valid flags
module promotable_priority_table_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ppt_pkg::MODE_W-1:0]     i_mode,
    input  logic [ppt_pkg::ID_W-1:0]       i_entry_id,
    input  logic [ppt_pkg::PAY_W-1:0]      i_payload,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ppt_pkg::STATUS_W-1:0]   o_status,
    output logic [ppt_pkg::ID_W-1:0]       o_result_id,
    output logic [ppt_pkg::PAY_W-1:0]      o_result_payload,
    output logic [ppt_pkg::PRIO_W-1:0]     o_result_priority,
    output logic                           o_id_live
);

    ppt_pkg::t_cmd  cmd;
    ppt_pkg::t_stat stat;
    logic           busy;
    logic           accept;

    // request accepted only while the controller sits idle
    assign accept  = i_valid && !busy;
    assign o_stall = busy;

    // state machine: idle, decode, scan, fetch of the winner, finish
    ppt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // storage, scan compare and result register
    ppt_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_mode            (i_mode),
        .i_entry_id        (i_entry_id),
        .i_payload         (i_payload),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_result_id       (o_result_id),
        .o_result_payload  (o_result_payload),
        .o_result_priority (o_result_priority),
        .o_id_live         (o_id_live)
    );

    // an accepted request keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("block not busy after accepting a request");

    // a new result only follows a busy cycle
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a request in progress");

    // full and empty answers carry no entry
    a_full_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ppt_pkg::ST_FULL || o_status == ppt_pkg::ST_EMPTY))
        |-> (o_result_id == '0 && !o_id_live && o_result_priority == '0))
        else $error("full or empty result carries entry data");

    // results are only loaded by the commit step, and only into a free register
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_valid || !i_stall))
        else $error("result register overwritten while stalled");

endmodule

// ----- src/ppt_ctrl.sv -----
// sequencing state machine of the promotable priority table
module ppt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  ppt_pkg::t_stat i_stat,
    output ppt_pkg::t_cmd  o_cmd,
    output logic          o_busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.scan_init = 1'b1;
                n_state = i_stat.is_scan ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- src/ppt_dp.sv -----
// table storage, max scan and result register of the promotable priority table
module ppt_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ppt_pkg::t_cmd                  i_cmd,
    output ppt_pkg::t_stat                 o_stat,
    input  logic [ppt_pkg::MODE_W-1:0]     i_mode,
    input  logic [ppt_pkg::ID_W-1:0]       i_entry_id,
    input  logic [ppt_pkg::PAY_W-1:0]      i_payload,
    input  logic                           i_stall,
    output logic                           o_valid,
    output logic [ppt_pkg::STATUS_W-1:0]   o_status,
    output logic [ppt_pkg::ID_W-1:0]       o_result_id,
    output logic [ppt_pkg::PAY_W-1:0]      o_result_payload,
    output logic [ppt_pkg::PRIO_W-1:0]     o_result_priority,
    output logic                           o_id_live
);

    // captured request
    logic [ppt_pkg::MODE_W-1:0] r_mode;
    logic [ppt_pkg::ID_W-1:0]   r_id;
    logic [ppt_pkg::PAY_W-1:0]  r_pay;

    // table state
    logic [ppt_pkg::CNT_W-1:0]   r_nfi;
    logic [ppt_pkg::ENTRIES-1:0] r_live;
    logic [ppt_pkg::PRIO_W-1:0]  mem_prio [ppt_pkg::ENTRIES];
    logic [ppt_pkg::PAY_W-1:0]   mem_pay  [ppt_pkg::ENTRIES];
    logic [ppt_pkg::PRIO_W-1:0]  r_rd_prio;
    logic [ppt_pkg::PAY_W-1:0]   r_rd_pay;

    // scan state
    logic [ppt_pkg::CNT_W-1:0]  r_scan;
    logic                       r_cmp_v;
    logic [ppt_pkg::ID_W-1:0]   r_cmp_idx;
    logic                       r_found;
    logic [ppt_pkg::ID_W-1:0]   r_best;
    logic [ppt_pkg::PRIO_W-1:0] r_best_prio;

    // result register
    logic                         r_out_valid;
    logic [ppt_pkg::STATUS_W-1:0] r_status;
    logic [ppt_pkg::ID_W-1:0]     r_res_id;
    logic [ppt_pkg::PAY_W-1:0]    r_res_pay;
    logic [ppt_pkg::PRIO_W-1:0]   r_res_prio;
    logic                         r_res_live;

    logic                         is_scan;
    logic                         is_full;
    logic                         id_ok;
    logic [ppt_pkg::ID_W-1:0]     rd_addr;
    logic [ppt_pkg::PRIO_W-1:0]   prio_up;
    logic                         prio_we;
    logic [ppt_pkg::ID_W-1:0]     prio_wa;
    logic [ppt_pkg::PRIO_W-1:0]   prio_wd;
    logic                         pay_we;
    logic                         set_live;
    logic                         clr_live;
    logic [ppt_pkg::STATUS_W-1:0] n_status;
    logic [ppt_pkg::ID_W-1:0]     n_res_id;
    logic [ppt_pkg::PAY_W-1:0]    n_res_pay;
    logic [ppt_pkg::PRIO_W-1:0]   n_res_prio;
    logic                         n_res_live;

    assign is_scan = (r_mode == ppt_pkg::MODE_PEEK) || (r_mode == ppt_pkg::MODE_POP);
    assign is_full = (r_nfi == ppt_pkg::CNT_W'(ppt_pkg::ENTRIES));
    assign id_ok   = ({1'b0, r_id} < r_nfi) && r_live[r_id];
    assign rd_addr = i_cmd.scan_run ? r_scan[ppt_pkg::ID_W-1:0] : (is_scan ? r_best : r_id);
    assign prio_up = (r_rd_prio == ppt_pkg::PRIO_MAX) ? r_rd_prio
                                                     : r_rd_prio + ppt_pkg::PRIO_W'(1);

    assign o_stat.is_scan  = is_scan;
    assign o_stat.scan_end = (r_scan == r_nfi);
    assign o_stat.out_free = !r_out_valid || !i_stall;

    // result fields and state updates for the finishing request
    always_comb begin
        prio_we    = 1'b0;
        prio_wa    = r_id;
        prio_wd    = prio_up;
        pay_we     = 1'b0;
        set_live   = 1'b0;
        clr_live   = 1'b0;
        n_status   = ppt_pkg::ST_BAD_ID;
        n_res_id   = '0;
        n_res_pay  = '0;
        n_res_prio = '0;
        n_res_live = 1'b0;
        case (r_mode)
            ppt_pkg::MODE_ADD: begin
                if (is_full) begin
                    n_status = ppt_pkg::ST_FULL;
                end else begin
                    n_status   = ppt_pkg::ST_OK;
                    n_res_id   = r_nfi[ppt_pkg::ID_W-1:0];
                    n_res_pay  = r_pay;
                    n_res_live = 1'b1;
                    prio_we    = 1'b1;
                    prio_wa    = r_nfi[ppt_pkg::ID_W-1:0];
                    prio_wd    = '0;
                    pay_we     = 1'b1;
                    set_live   = 1'b1;
                end
            end
            ppt_pkg::MODE_PROMOTE, ppt_pkg::MODE_GET: begin
                n_res_id = r_id;
                if (id_ok) begin
                    n_status   = ppt_pkg::ST_OK;
                    n_res_pay  = r_rd_pay;
                    n_res_live = 1'b1;
                    if (r_mode == ppt_pkg::MODE_PROMOTE) begin
                        n_res_prio = prio_up;
                        prio_we    = 1'b1;
                    end else begin
                        n_res_prio = r_rd_prio;
                    end
                end
            end
            ppt_pkg::MODE_PEEK, ppt_pkg::MODE_POP: begin
                if (!r_found) begin
                    n_status = ppt_pkg::ST_EMPTY;
                end else begin
                    n_status   = ppt_pkg::ST_OK;
                    n_res_id   = r_best;
                    n_res_pay  = r_rd_pay;
                    n_res_prio = r_best_prio;
                    n_res_live = (r_mode == ppt_pkg::MODE_PEEK);
                    clr_live   = (r_mode == ppt_pkg::MODE_POP);
                end
            end
            default: begin
                n_status = ppt_pkg::ST_BAD_ID;
            end
        endcase
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_id   <= i_entry_id;
            r_pay  <= i_payload;
        end
    end

    // storage with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && prio_we) begin
            mem_prio[prio_wa] <= prio_wd;
        end
        if (i_cmd.commit && pay_we) begin
            mem_pay[r_nfi[ppt_pkg::ID_W-1:0]] <= r_pay;
        end
        r_rd_prio <= mem_prio[rd_addr];
        r_rd_pay  <= mem_pay[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfi  <= '0;
            r_live <= '0;
        end else if (i_cmd.commit) begin
            if (set_live) begin
                r_live[r_nfi[ppt_pkg::ID_W-1:0]] <= 1'b1;
                r_nfi <= r_nfi + ppt_pkg::CNT_W'(1);
            end
            if (clr_live) begin
                r_live[r_best] <= 1'b0;
            end
        end
    end

    // max scan: issue one address a cycle, compare the entry read the cycle before
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_v <= 1'b0;
            r_found <= 1'b0;
            r_scan  <= '0;
        end else if (i_cmd.scan_init) begin
            r_cmp_v <= 1'b0;
            r_found <= 1'b0;
            r_scan  <= '0;
        end else begin
            r_cmp_v <= i_cmd.scan_run && !o_stat.scan_end;
            if (i_cmd.scan_run && !o_stat.scan_end) begin
                r_scan <= r_scan + ppt_pkg::CNT_W'(1);
            end
            if (r_cmp_v && r_live[r_cmp_idx] && (!r_found || r_rd_prio >= r_best_prio)) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_best <= '0;
        end else if (r_cmp_v && r_live[r_cmp_idx] && (!r_found || r_rd_prio >= r_best_prio)) begin
            r_best      <= r_cmp_idx;
            r_best_prio <= r_rd_prio;
        end
        r_cmp_idx <= r_scan[ppt_pkg::ID_W-1:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status   <= n_status;
            r_res_id   <= n_res_id;
            r_res_pay  <= n_res_pay;
            r_res_prio <= n_res_prio;
            r_res_live <= n_res_live;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_result_id       = r_res_id;
    assign o_result_payload  = r_res_pay;
    assign o_result_priority = r_res_prio;
    assign o_id_live         = r_res_live;

endmodule

// ----- tb/sv/tb_promotable_priority_table_core.sv -----
// testbench of the promotable priority table: directed, promote burst, random and backpressure tests
`timescale 1ns / 100ps

module tb_promotable_priority_table_core;

    localparam int CLK_PERIOD     = 20;
    localparam int IDLE_PCT       = 22;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off of the backpressure test
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES   = 100;   // longer than the slowest scan
    localparam int MAX_LINES      = 60;
    localparam int BURST_LEN      = 30;    // promotes of one entry with no idling

    typedef struct packed {
        logic [ppt_pkg::STATUS_W-1:0] status;
        logic [ppt_pkg::ID_W-1:0]     id;
        logic [ppt_pkg::PAY_W-1:0]    payload;
        logic [ppt_pkg::PRIO_W-1:0]   priority_val;
        logic                         live;
    } t_table_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [ppt_pkg::MODE_W-1:0]   i_mode;
    logic [ppt_pkg::ID_W-1:0]     i_entry_id;
    logic [ppt_pkg::PAY_W-1:0]    i_payload;
    logic                         o_valid;
    logic                         i_stall;
    logic [ppt_pkg::STATUS_W-1:0] o_status;
    logic [ppt_pkg::ID_W-1:0]     o_result_id;
    logic [ppt_pkg::PAY_W-1:0]    o_result_payload;
    logic [ppt_pkg::PRIO_W-1:0]   o_result_priority;
    logic                         o_id_live;

    // shadow copy of the table
    logic [ppt_pkg::CNT_W-1:0]  tbl_count;
    logic                       tbl_live [ppt_pkg::ENTRIES];
    logic [ppt_pkg::PRIO_W-1:0] tbl_prio [ppt_pkg::ENTRIES];
    logic [ppt_pkg::PAY_W-1:0]  tbl_pay  [ppt_pkg::ENTRIES];

    t_table_result pending_results[$];
    int            error_count;
    int            quiet_cycles;
    bit            idle_on;
    bit            hold_req;
    bit            hold_taken;
    int            hold_left;

    promotable_priority_table_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_entry_id        (i_entry_id),
        .i_payload         (i_payload),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_result_id       (o_result_id),
        .o_result_payload  (o_result_payload),
        .o_result_priority (o_result_priority),
        .o_id_live         (o_id_live)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // applies one request to the shadow table and returns the answer it must give
    function automatic t_table_result apply_table_op(input logic [ppt_pkg::MODE_W-1:0] mode,
                                                     input logic [ppt_pkg::ID_W-1:0] id,
                                                     input logic [ppt_pkg::PAY_W-1:0] pay);
        t_table_result r;
        int            best;
        bit            found;
        int            n;
        r     = '0;
        best  = 0;
        found = 1'b0;
        case (mode)
            ppt_pkg::MODE_ADD: begin
                if (tbl_count >= ppt_pkg::CNT_W'(ppt_pkg::ENTRIES)) begin
                    r.status = ppt_pkg::ST_FULL;
                end else begin
                    n           = int'(tbl_count);
                    tbl_pay[n]  = pay;
                    tbl_prio[n] = '0;
                    tbl_live[n] = 1'b1;
                    tbl_count   = tbl_count + ppt_pkg::CNT_W'(1);
                    r.status    = ppt_pkg::ST_OK;
                    r.id        = n[ppt_pkg::ID_W-1:0];
                    r.payload   = pay;
                    r.live      = 1'b1;
                end
            end
            ppt_pkg::MODE_PROMOTE, ppt_pkg::MODE_GET: begin
                r.id = id;
                if (!(({1'b0, id} < tbl_count) && tbl_live[id])) begin
                    r.status = ppt_pkg::ST_BAD_ID;
                end else begin
                    // saturates at the top priority
                    if (mode == ppt_pkg::MODE_PROMOTE && tbl_prio[id] != ppt_pkg::PRIO_MAX)
                        tbl_prio[id] = tbl_prio[id] + ppt_pkg::PRIO_W'(1);
                    r.status       = ppt_pkg::ST_OK;
                    r.payload      = tbl_pay[id];
                    r.priority_val = tbl_prio[id];
                    r.live         = 1'b1;
                end
            end
            ppt_pkg::MODE_PEEK, ppt_pkg::MODE_POP: begin
                // larger id wins a tie, hence >=
                for (int i = 0; i < int'(tbl_count); i++) begin
                    if (tbl_live[i] && (!found || tbl_prio[i] >= tbl_prio[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = ppt_pkg::ST_EMPTY;
                end else begin
                    r.status       = ppt_pkg::ST_OK;
                    r.id           = best[ppt_pkg::ID_W-1:0];
                    r.payload      = tbl_pay[best];
                    r.priority_val = tbl_prio[best];
                    r.live         = (mode == ppt_pkg::MODE_PEEK);
                    if (mode == ppt_pkg::MODE_POP)
                        tbl_live[best] = 1'b0;
                end
            end
            default: begin
                r.status = ppt_pkg::ST_BAD_ID;
            end
        endcase
        return r;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_LINES)
            $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    // appends the answer of an accepted request behind the older ones
    task automatic queue_expected(input t_table_result r);
        pending_results.insert(pending_results.size(), r);
    endtask

    // offers one request from a falling edge until it is taken, returns at the next falling edge
    task automatic send_req(input logic [ppt_pkg::MODE_W-1:0] mode,
                            input logic [ppt_pkg::ID_W-1:0] id,
                            input logic [ppt_pkg::PAY_W-1:0] pay);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= mode;
        i_entry_id <= id;
        i_payload  <= pay;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        queue_expected(apply_table_op(mode, id, pay));
        @(negedge i_clk);
    endtask

    task automatic stop_reqs();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // random request; well-formed ids mostly name an already handed-out entry
    task automatic send_random(input int w_add, input int w_prom, input int w_get,
                               input int w_peek, input int w_pop, input int w_spare);
        int                         pick;
        logic [ppt_pkg::MODE_W-1:0] mode;
        logic [ppt_pkg::ID_W-1:0]   id;
        pick = $urandom_range(w_add + w_prom + w_get + w_peek + w_pop + w_spare - 1);
        if (pick < w_add)
            mode = ppt_pkg::MODE_ADD;
        else if (pick < w_add + w_prom)
            mode = ppt_pkg::MODE_PROMOTE;
        else if (pick < w_add + w_prom + w_get)
            mode = ppt_pkg::MODE_GET;
        else if (pick < w_add + w_prom + w_get + w_peek)
            mode = ppt_pkg::MODE_PEEK;
        else if (pick < w_add + w_prom + w_get + w_peek + w_pop)
            mode = ppt_pkg::MODE_POP;
        else
            mode = ppt_pkg::MODE_W'($urandom_range(2 ** ppt_pkg::MODE_W - 1,
                                                   int'(ppt_pkg::MODE_POP) + 1));
        if (tbl_count != 0 && $urandom_range(99) < 85)
            id = ppt_pkg::ID_W'($urandom_range(int'(tbl_count) - 1));
        else
            id = ppt_pkg::ID_W'($urandom_range(ppt_pkg::ENTRIES - 1));
        send_req(mode, id, ppt_pkg::PAY_W'($urandom));
    endtask

    // receiver: random stalls, plus a single long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // result check against the oldest pending answer
    always @(posedge i_clk) begin
        t_table_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_error("result with no request pending");
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_error($sformatf("status got %0d expected %0d",
                                           o_status, want.status));
                if (o_result_id !== want.id)
                    report_error($sformatf("result_id got %0d expected %0d",
                                           o_result_id, want.id));
                if (o_result_payload !== want.payload)
                    report_error($sformatf("result_payload got %h expected %h",
                                           o_result_payload, want.payload));
                if (o_result_priority !== want.priority_val)
                    report_error($sformatf("result_priority got %0d expected %0d",
                                           o_result_priority, want.priority_val));
                if (o_id_live !== want.live)
                    report_error($sformatf("id_live got %b expected %b",
                                           o_id_live, want.live));
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("promotable_priority_table_core test failed");
                $finish;
            end
        end
    end

    task automatic test_directed_cases();
        // empty table, never-issued ids and unused modes
        send_req(ppt_pkg::MODE_PEEK, '0, '0);
        send_req(ppt_pkg::MODE_POP, '0, '0);
        send_req(ppt_pkg::MODE_PROMOTE, '0, '0);
        send_req(ppt_pkg::MODE_GET, '1, '1);
        for (int m = int'(ppt_pkg::MODE_POP) + 1; m < 2 ** ppt_pkg::MODE_W; m++)
            send_req(ppt_pkg::MODE_W'(m), '1, '1);
        // payload extremes
        send_req(ppt_pkg::MODE_ADD, '1, '0);
        send_req(ppt_pkg::MODE_ADD, '0, '1);
        send_req(ppt_pkg::MODE_ADD, '0, 32'hA5A5_5A5A);
        // three entries tied at zero: the largest id wins
        send_req(ppt_pkg::MODE_PEEK, '0, '0);
        send_req(ppt_pkg::MODE_PROMOTE, ppt_pkg::ID_W'(1), '0);
        send_req(ppt_pkg::MODE_GET, ppt_pkg::ID_W'(1), '0);
        // id equal to the count is not issued yet
        send_req(ppt_pkg::MODE_GET, ppt_pkg::ID_W'(3), '0);
        send_req(ppt_pkg::MODE_POP, '0, '0);
        // dead entry
        send_req(ppt_pkg::MODE_GET, ppt_pkg::ID_W'(1), '0);
        send_req(ppt_pkg::MODE_PROMOTE, ppt_pkg::ID_W'(1), '0);
        send_req(ppt_pkg::MODE_POP, '0, '0);
        send_req(ppt_pkg::MODE_POP, '0, '0);
        // ids issued but none live
        send_req(ppt_pkg::MODE_PEEK, '0, '0);
        send_req(ppt_pkg::MODE_ADD, '0, ppt_pkg::PAY_W'($urandom));
    endtask

    // promote one entry many times in a row, with no idling on either side
    task automatic test_promote_burst();
        logic [ppt_pkg::ID_W-1:0] burst_id;
        idle_on  = 1'b0;
        burst_id = tbl_count[ppt_pkg::ID_W-1:0];
        send_req(ppt_pkg::MODE_ADD, '0, ppt_pkg::PAY_W'($urandom));
        for (int i = 0; i < BURST_LEN; i++)
            send_req(ppt_pkg::MODE_PROMOTE, burst_id, ppt_pkg::PAY_W'($urandom));
        send_req(ppt_pkg::MODE_GET, burst_id, '0);
        send_req(ppt_pkg::MODE_POP, '0, '0);
        idle_on = 1'b1;
    endtask

    // add-heavy mix until the table runs full
    task automatic test_random_fill();
        for (int i = 0; i < 500; i++)
            send_random(20, 35, 15, 12, 10, 3);
    endtask

    // receiver holds off while requests keep coming, so the block stalls its input
    task automatic test_input_backpressure();
        stop_reqs();
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < 20; i++)
            send_random(5, 40, 30, 10, 10, 5);
    endtask

    // pop-heavy mix that drains the table and keeps hitting it empty
    task automatic test_random_drain();
        for (int i = 0; i < 500; i++)
            send_random(10, 25, 15, 15, 30, 5);
    endtask

    task automatic finish_run();
        stop_reqs();
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0) begin
            $display("promotable_priority_table_core test passed");
        end else begin
            $display("promotable_priority_table_core test failed");
        end
        $finish;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_mode       = ppt_pkg::MODE_ADD;
        i_entry_id   = '0;
        i_payload    = '0;
        tbl_count    = '0;
        error_count  = 0;
        quiet_cycles = 0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        hold_taken   = 1'b0;
        hold_left    = 0;
        for (int i = 0; i < ppt_pkg::ENTRIES; i++) begin
            tbl_live[i] = 1'b0;
            tbl_prio[i] = '0;
            tbl_pay[i]  = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_cases();
        test_promote_burst();
        test_random_fill();
        test_input_backpressure();
        test_random_drain();
        finish_run();
    end

endmodule
